// ===== sv/scex_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scex_pkg
// command and status codes, word layout and cell control shared by the
// stack calculator execution unit
// ----------------------------------------------------------------------------
package scex_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [DATA_W-1:0]   t_data;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_PUSH  = 3'd0;
    localparam t_cmd CMD_POP   = 3'd1;
    localparam t_cmd CMD_ADD   = 3'd2;
    localparam t_cmd CMD_MUL   = 3'd3;
    localparam t_cmd CMD_PRINT = 3'd4;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_UNDER   = 2'd1;
    localparam t_status ST_UNKNOWN = 2'd2;
    localparam t_status ST_OVER    = 2'd3;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // load_above: take the neighbor nearer the top (push direction)
    // load_below: take the neighbor farther from the top (pop direction)
    typedef struct packed {
        logic load_above;
        logic load_below;
    } t_cell_ctl;

endpackage

// ===== sv/scex_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scex_cell
// one stack entry; shifts toward or away from the top on command
// ----------------------------------------------------------------------------
module scex_cell (
    input  logic               i_clk,
    input  scex_pkg::t_cell_ctl i_ctl,
    input  scex_pkg::t_data    i_above,
    input  scex_pkg::t_data    i_below,
    output scex_pkg::t_data    o_data
);

    scex_pkg::t_data r_data;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load_above) begin
            r_data <= i_above;
        end else if (i_ctl.load_below) begin
            r_data <= i_below;
        end else begin
            r_data <= r_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== sv/scex_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scex_alu
// wrapped 32-bit add or multiply of the top two stack entries
// ----------------------------------------------------------------------------
module scex_alu (
    input  logic            i_is_mul,
    input  scex_pkg::t_data i_a,
    input  scex_pkg::t_data i_b,
    output scex_pkg::t_data o_result
);

    scex_pkg::t_data w_sum;
    scex_pkg::t_data w_prod;

    assign w_sum    = i_a + i_b;
    assign w_prod   = i_a * i_b;
    assign o_result = i_is_mul ? w_prod : w_sum;

endmodule

// ===== sv/stack_calculator_exec_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_calculator_exec_unit
// stack machine executing push, pop, add, mul and print on a row of cells
// ----------------------------------------------------------------------------
// The operand stack is a row of STACK_DEPTH cells with the top entry always
// in the first cell; push shifts every cell one place down, pop shifts up,
// and add or mul writes the result into the first cell while the rest shift
// up. Each instruction word is executed in the cycle it is accepted and its
// result word appears from the output register in the next cycle, so one
// word per clock is sustained while m_axis_tready holds; the multiplier
// feeding the top cell is combinational. A new word is accepted while the output
// register is empty or being drained. Errors (underflow, overflow, unknown
// command) leave the stack as it was. No clearing pass is needed after reset.
module stack_calculator_exec_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // push_value
    input  logic [scex_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [scex_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // shown_value, stack_count, zero pad
    output logic [scex_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status, shown_valid
    output logic [scex_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic              w_accept;
    scex_pkg::t_cmd    w_cmd;
    scex_pkg::t_data   w_cell_q [STACK_DEPTH];
    scex_pkg::t_data   w_alu_result;
    scex_pkg::t_data   w_head_in;
    logic              w_has1;
    logic              w_has2;
    logic              w_full;

    scex_pkg::t_cell_ctl w_head_ctl;
    scex_pkg::t_cell_ctl w_body_ctl;
    scex_pkg::t_cell_ctl n_head_ctl;
    scex_pkg::t_cell_ctl n_body_ctl;
    logic                n_head_sel_alu;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    scex_pkg::t_status n_status;
    logic              n_shown_valid;
    scex_pkg::t_data   n_shown_value;

    logic              r_out_valid;
    scex_pkg::t_status r_status;
    logic              r_shown_valid;
    scex_pkg::t_data   r_shown_value;
    logic [CW-1:0]     r_out_count;

    assign w_cmd         = s_axis_tuser;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_has1 = (r_count != '0);
    assign w_has2 = (r_count >= CW'(2));
    assign w_full = (r_count == CW'(STACK_DEPTH));

    always_comb begin
        n_status       = scex_pkg::ST_OK;
        n_shown_valid  = 1'b0;
        n_shown_value  = '0;
        n_count        = r_count;
        n_head_ctl     = '0;
        n_body_ctl     = '0;
        n_head_sel_alu = 1'b0;
        unique case (w_cmd)
            scex_pkg::CMD_PUSH: begin
                if (w_full) begin
                    n_status = scex_pkg::ST_OVER;
                end else begin
                    n_head_ctl.load_above = 1'b1;
                    n_body_ctl.load_above = 1'b1;
                    n_count               = r_count + CW'(1);
                end
            end
            scex_pkg::CMD_POP: begin
                if (!w_has1) begin
                    n_status = scex_pkg::ST_UNDER;
                end else begin
                    n_head_ctl.load_below = 1'b1;
                    n_body_ctl.load_below = 1'b1;
                    n_count               = r_count - CW'(1);
                end
            end
            scex_pkg::CMD_ADD, scex_pkg::CMD_MUL: begin
                if (!w_has2) begin
                    n_status = scex_pkg::ST_UNDER;
                end else begin
                    n_head_ctl.load_above = 1'b1;
                    n_head_sel_alu        = 1'b1;
                    n_body_ctl.load_below = 1'b1;
                    n_count               = r_count - CW'(1);
                end
            end
            scex_pkg::CMD_PRINT: begin
                if (!w_has1) begin
                    n_status = scex_pkg::ST_UNDER;
                end else begin
                    n_shown_valid = 1'b1;
                    n_shown_value = w_cell_q[0];
                end
            end
            default: begin
                n_status = scex_pkg::ST_UNKNOWN;
            end
        endcase
    end

    assign w_head_ctl = w_accept ? n_head_ctl : '0;
    assign w_body_ctl = w_accept ? n_body_ctl : '0;
    assign w_head_in  = n_head_sel_alu ? w_alu_result : s_axis_tdata[scex_pkg::DATA_W-1:0];

    scex_alu u_alu (
        .i_is_mul (w_cmd == scex_pkg::CMD_MUL),
        .i_a      (w_cell_q[0]),
        .i_b      (w_cell_q[1]),
        .o_result (w_alu_result)
    );

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        scex_pkg::t_data w_above;
        scex_pkg::t_data w_below;
        scex_pkg::t_cell_ctl w_ctl;

        if (g == 0) begin : g_head
            assign w_above = w_head_in;
            assign w_ctl   = w_head_ctl;
        end else begin : g_body
            assign w_above = w_cell_q[g-1];
            assign w_ctl   = w_body_ctl;
        end

        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_below = '0;
        end else begin : g_mid
            assign w_below = w_cell_q[g+1];
        end

        scex_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_data  (w_cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_shown_valid <= n_shown_valid;
            r_shown_value <= n_shown_value;
            r_out_count   <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_shown_valid, r_status};
    assign m_axis_tdata  = {3'b000, scex_pkg::COUNT_W'(r_out_count), r_shown_value};

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == scex_pkg::CMD_PUSH && !w_full)
        |=> (r_count == $past(r_count) + CW'(1)
             && w_cell_q[0] == $past(s_axis_tdata[scex_pkg::DATA_W-1:0])))
        else $error("push did not land on top");

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status != scex_pkg::ST_OK) |=> $stable(r_count))
        else $error("error word changed the stack count");

    a_shown_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_shown_valid) |-> (r_status == scex_pkg::ST_OK))
        else $error("shown value with error status");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count == r_count))
        else $error("reported count differs from stack");

endmodule

// ===== test/tb_stack_calculator_exec_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_calculator_exec_unit
// self-checking bench for the stack calculator execution unit
// ----------------------------------------------------------------------------
// Instruction words go in on the slave stream and each one is run through a
// local model of the operand stack, which queues the result word it should
// produce. Result words from the master stream are compared field by field
// against the oldest queued result. Directed runs cover the empty stack,
// unknown commands, wrap-around arithmetic and a full stack; a long random
// program with changing push bias then walks the stack between empty and
// full. Both streams stall at random, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_stack_calculator_exec_unit;

    localparam int DEPTH        = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_WORDS = 1750;

    typedef logic [scex_pkg::COUNT_W-1:0] t_count;

    typedef struct packed {
        scex_pkg::t_status status;
        logic              shown_valid;
        scex_pkg::t_data   shown_value;
        t_count            stack_count;
    } t_exec_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // push_value
    logic [scex_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
    // cmd
    logic [scex_pkg::S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // shown_value, stack_count, zero pad
    logic [scex_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    // status, shown_valid
    logic [scex_pkg::M_TUSER_W-1:0]  m_axis_tuser;

    scex_pkg::t_data operand_stack [DEPTH];
    int              operand_count = 0;
    t_exec_result    pending_results [$];
    int              error_count = 0;
    int              result_index = 0;
    int              idle_cycles = 0;
    int              ready_stall_left = 0;
    bit              tx_gaps_on = 1'b1;
    bit              rx_stalls_on = 1'b1;

    stack_calculator_exec_unit #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run one instruction on the local stack and return its result word
    function automatic t_exec_result exec_instr(scex_pkg::t_cmd cmd,
                                                scex_pkg::t_data value);
        t_exec_result    res;
        scex_pkg::t_data lhs;
        scex_pkg::t_data rhs;
        res = '0;
        res.status = scex_pkg::ST_OK;
        case (cmd)
            scex_pkg::CMD_PUSH: begin
                if (operand_count >= DEPTH) begin
                    res.status = scex_pkg::ST_OVER;
                end else begin
                    operand_stack[operand_count] = value;
                    operand_count++;
                end
            end
            scex_pkg::CMD_POP: begin
                if (operand_count < 1) res.status = scex_pkg::ST_UNDER;
                else operand_count--;
            end
            scex_pkg::CMD_ADD, scex_pkg::CMD_MUL: begin
                if (operand_count < 2) begin
                    res.status = scex_pkg::ST_UNDER;
                end else begin
                    lhs = operand_stack[operand_count-1];
                    rhs = operand_stack[operand_count-2];
                    operand_stack[operand_count-2] =
                        (cmd == scex_pkg::CMD_ADD) ? lhs + rhs : lhs * rhs;
                    operand_count--;
                end
            end
            scex_pkg::CMD_PRINT: begin
                if (operand_count < 1) begin
                    res.status = scex_pkg::ST_UNDER;
                end else begin
                    res.shown_valid = 1'b1;
                    res.shown_value = operand_stack[operand_count-1];
                end
            end
            default: res.status = scex_pkg::ST_UNKNOWN;
        endcase
        res.stack_count = t_count'(operand_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR word %0d %s: got 0x%0h expected 0x%0h", result_index, what, got, want);
        error_count++;
    endtask

    // input capture and result checking share one edge-triggered process
    always @(posedge i_clk) begin
        t_exec_result got;
        t_exec_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(exec_instr(scex_pkg::t_cmd'(s_axis_tuser),
                                                     s_axis_tdata[scex_pkg::DATA_W-1:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.status      = m_axis_tuser[1:0];
                got.shown_valid = m_axis_tuser[2];
                got.shown_value = m_axis_tdata[31:0];
                got.stack_count = m_axis_tdata[36:32];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.shown_valid != want.shown_valid)
                        report_mismatch("shown_valid", got.shown_valid, want.shown_valid);
                    if (got.shown_value != want.shown_value)
                        report_mismatch("shown_value", got.shown_value, want.shown_value);
                    if (got.stack_count != want.stack_count)
                        report_mismatch("stack_count", got.stack_count, want.stack_count);
                end
                result_index++;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!rx_stalls_on) begin
            m_axis_tready <= 1'b1;
        end else if (ready_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            ready_stall_left <= ready_stall_left - 1;
        end else if ($urandom_range(0, 99) < 65) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            ready_stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                            : $urandom_range(6, 40);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("stack_calculator_exec_unit verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_gaps_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_word(scex_pkg::t_cmd cmd, scex_pkg::t_data value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic scex_pkg::t_data pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            5, 6: return scex_pkg::t_data'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_stack();
        send_word(scex_pkg::CMD_POP, 32'h0);
        send_word(scex_pkg::CMD_PRINT, 32'h0);
        send_word(scex_pkg::CMD_ADD, 32'h0);
        send_word(scex_pkg::CMD_MUL, 32'h0);
        send_word(scex_pkg::t_cmd'(5), 32'hffff_ffff);
        send_word(scex_pkg::t_cmd'(6), 32'h0);
        send_word(scex_pkg::t_cmd'(7), 32'h1234_5678);
        // one entry is still too few for add and mul
        send_word(scex_pkg::CMD_PUSH, 32'h0000_0005);
        send_word(scex_pkg::CMD_ADD, 32'h0);
        send_word(scex_pkg::CMD_MUL, 32'h0);
        send_word(scex_pkg::CMD_POP, 32'h0);
    endtask

    task automatic test_wrap_arith();
        send_word(scex_pkg::CMD_PUSH, 32'h7fff_ffff);
        send_word(scex_pkg::CMD_PUSH, 32'h0000_0001);
        send_word(scex_pkg::CMD_ADD, 32'hffff_ffff);
        send_word(scex_pkg::CMD_PRINT, 32'h0);
        send_word(scex_pkg::CMD_PUSH, 32'hffff_ffff);
        send_word(scex_pkg::CMD_MUL, 32'h0);
        send_word(scex_pkg::CMD_PRINT, 32'h0);
        send_word(scex_pkg::CMD_POP, 32'h0);
    endtask

    task automatic test_full_stack();
        for (int i = 0; i < DEPTH; i++)
            send_word(scex_pkg::CMD_PUSH, (i % 2) ? 32'haaaa_aaaa : 32'h5555_5555);
        // a push onto a full stack is refused
        send_word(scex_pkg::CMD_PUSH, 32'hdead_beef);
        send_word(scex_pkg::CMD_PRINT, 32'h0);
        send_word(scex_pkg::CMD_MUL, 32'h0);
    endtask

    task automatic test_random_program();
        int             sent;
        int             seg_len;
        int             push_weight;
        int             r;
        scex_pkg::t_cmd cmd;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            seg_len      = $urandom_range(40, 150);
            if (seg_len > RANDOM_WORDS - sent) seg_len = RANDOM_WORDS - sent;
            push_weight  = $urandom_range(10, 85);
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < seg_len; i++) begin
                r = $urandom_range(0, 99);
                if (r < push_weight) begin
                    cmd = scex_pkg::CMD_PUSH;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 25) cmd = scex_pkg::CMD_POP;
                    else if (r < 50) cmd = scex_pkg::CMD_ADD;
                    else if (r < 70) cmd = scex_pkg::CMD_MUL;
                    else if (r < 90) cmd = scex_pkg::CMD_PRINT;
                    else cmd = scex_pkg::t_cmd'($urandom_range(5, 7));
                end
                send_word(cmd, pick_value());
            end
            sent += seg_len;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_stack();
        test_wrap_arith();
        test_full_stack();
        test_random_program();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("stack_calculator_exec_unit verification clean");
        else
            $display("stack_calculator_exec_unit verification failed");
        $finish;
    end

endmodule
